>>> hw/rtl/tcd_pkg.sv
// Shared types and constants for the periodic down-counter timer.
// Request/response payloads, register and operation codes, step unit result.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcd_pkg;

    localparam int WORD_W = 32;
    localparam int TICK_W = 16;

    // operation codes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // bus register map
    localparam logic [3:0] REG_TICKS_LO = 4'd0;
    localparam logic [3:0] REG_TICKS_HI = 4'd1;
    localparam logic [3:0] REG_GCFG     = 4'd2;
    localparam logic [3:0] REG_TCFG     = 4'd3;
    localparam logic [3:0] REG_STATE    = 4'd4;
    localparam logic [3:0] REG_BUF      = 4'd5;
    localparam logic [3:0] REG_BUF2     = 4'd6;
    localparam logic [3:0] REG_VALUE    = 4'd7;
    localparam logic [3:0] REG_LATCH    = 4'd8;
    localparam logic [3:0] REG_STATUS   = 4'd9;
    localparam logic [3:0] REG_ACK      = 4'd10;

    // configuration register indexes and reset values
    localparam logic [1:0] CFG_START  = 2'd0;
    localparam logic [1:0] CFG_UPDATE = 2'd1;
    localparam logic [1:0] CFG_EXPIRY = 2'd2;

    localparam logic [WORD_W-1:0] START_MASK_RST  = 32'd1;
    localparam logic [WORD_W-1:0] UPDATE_MASK_RST = 32'd2;
    localparam logic [WORD_W-1:0] EXPIRY_BITS_RST = 32'd1;

    typedef struct packed {
        logic [1:0]        operation;
        logic [3:0]        register_index;
        logic [WORD_W-1:0] write_data;
        logic [TICK_W-1:0] tick_count;
    } tcd_req_t;

    typedef struct packed {
        logic [WORD_W-1:0] read_data;
        logic              irq_pending;
    } tcd_rsp_t;

    // result of stepping the down-counter by one tick
    typedef struct packed {
        logic [WORD_W-1:0] live_next;
        logic              expire;
        logic              stop;
    } tcd_step_t;

    // sequencer -> register file controls
    typedef struct packed {
        logic bus_wr;
        logic tick_add;
        logic step_en;
    } tcd_ctrl_t;

    // register file -> sequencer status
    typedef struct packed {
        logic start_active;
        logic irq_pending;
        logic step_stop;
    } tcd_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/tcd_tick_step.sv
// One-tick step of the reloading down-counter: reload, decrement, zero compare.
// Depends on tcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcd_tick_step (
    input  wire logic [tcd_pkg::WORD_W-1:0] live_count,
    input  wire logic [tcd_pkg::WORD_W-1:0] count_buffer,
    output tcd_pkg::tcd_step_t              step
);
    import tcd_pkg::*;

    logic [WORD_W-1:0] start_val;
    logic [WORD_W-1:0] dec_val;

    // an empty counter reloads first; an empty buffer stops counting
    assign start_val = (live_count == '0) ? count_buffer : live_count;
    assign dec_val   = start_val - WORD_W'(1);

    always_comb begin
        step.stop      = (start_val == '0);
        step.expire    = !step.stop && (dec_val == '0);
        step.live_next = step.stop ? live_count : (step.expire ? count_buffer : dec_val);
    end

endmodule

`default_nettype wire

>>> hw/rtl/tcd_regfile.sv
// Timer register file: bus read mux, bus writes, free-running tick counter,
// and down-counter updates from the shared step unit. Depends on tcd_pkg,
// tcd_tick_step.
`timescale 1ns / 1ps
`default_nettype none

module tcd_regfile (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire tcd_pkg::tcd_ctrl_t         ctrl,
    input  wire logic [3:0]                 reg_index,
    input  wire logic [tcd_pkg::WORD_W-1:0] wr_data,
    input  wire logic [tcd_pkg::TICK_W-1:0] tick_add_val,
    input  wire logic [tcd_pkg::WORD_W-1:0] start_mask,
    input  wire logic [tcd_pkg::WORD_W-1:0] update_mask,
    input  wire logic [tcd_pkg::WORD_W-1:0] expiry_bits,
    output logic      [tcd_pkg::WORD_W-1:0] rd_data,
    output tcd_pkg::tcd_stat_t              stat
);
    import tcd_pkg::*;

    logic [2*WORD_W-1:0] ticks_reg;
    logic [WORD_W-1:0]   gcfg_reg;
    logic [WORD_W-1:0]   tcfg_reg;
    logic [WORD_W-1:0]   tstate_reg;
    logic [WORD_W-1:0]   buf_reg;
    logic [WORD_W-1:0]   buf2_reg;
    logic [WORD_W-1:0]   live_reg;
    logic [WORD_W-1:0]   latch_reg;
    tcd_step_t           step;

    tcd_tick_step u_step (
        .live_count   (live_reg),
        .count_buffer (buf_reg),
        .step         (step)
    );

    // bus read mux
    always_comb begin
        unique case (reg_index)
            REG_TICKS_LO: rd_data = ticks_reg[WORD_W-1:0];
            REG_TICKS_HI: rd_data = ticks_reg[2*WORD_W-1:WORD_W];
            REG_GCFG:     rd_data = gcfg_reg;
            REG_TCFG:     rd_data = tcfg_reg;
            REG_STATE:    rd_data = tstate_reg;
            REG_BUF:      rd_data = buf_reg;
            REG_BUF2:     rd_data = buf2_reg;
            REG_VALUE:    rd_data = live_reg;
            REG_LATCH:    rd_data = latch_reg;
            REG_STATUS:   rd_data = latch_reg;
            default:      rd_data = '0;
        endcase
    end

    always_comb begin
        stat.start_active = ((tstate_reg & start_mask) != '0);
        stat.irq_pending  = (latch_reg != '0);
        stat.step_stop    = step.stop;
    end

    // state updates: one bus write, one batch add or one tick step per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg  <= '0;
            gcfg_reg   <= '0;
            tcfg_reg   <= '0;
            tstate_reg <= '0;
            buf_reg    <= '0;
            buf2_reg   <= '0;
            live_reg   <= '0;
            latch_reg  <= '0;
        end else begin
            if (ctrl.bus_wr) begin
                unique case (reg_index)
                    REG_GCFG: gcfg_reg <= wr_data;
                    REG_TCFG: tcfg_reg <= wr_data;
                    REG_STATE: begin
                        tstate_reg <= wr_data;
                        if ((wr_data & update_mask) != '0) begin
                            live_reg <= buf_reg;
                        end
                    end
                    REG_BUF: begin
                        buf_reg  <= wr_data;
                        live_reg <= wr_data;
                    end
                    REG_BUF2:            buf2_reg  <= wr_data;
                    REG_LATCH, REG_ACK:  latch_reg <= latch_reg & ~wr_data;
                    REG_STATUS:          latch_reg <= '0;
                    default: ;
                endcase
            end
            if (ctrl.tick_add) begin
                ticks_reg <= ticks_reg + (2*WORD_W)'(tick_add_val);
            end
            if (ctrl.step_en) begin
                live_reg <= step.live_next;
                if (step.expire) begin
                    latch_reg <= latch_reg | expiry_bits;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/timer_counter_decrementer_regs_top.sv
// Top level of the periodic down-counter timer: request/response handshake,
// configuration registers and the tick sequencer. Depends on tcd_pkg,
// tcd_regfile.
`timescale 1ns / 1ps
`default_nettype none

// A request is taken when s_valid and s_ready are high and is answered by one
// response. A bus read or write goes to the done state. A tick batch of n ticks
// runs in the tick state while counting is enabled, as the single
// decrement/compare unit steps the down-counter one tick per cycle; it ends early
// once the counter is stopped by an empty count buffer, and goes to the done state
// at once when counting is disabled or n is zero. Only the low TICK_BATCH_BITS
// bits of tick_count are used. s_ready is high only between requests; a new
// request may be taken while the previous response waits in the output register.
module timer_counter_decrementer_regs_top #(
    parameter int TICK_BATCH_BITS = 16
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_wr_en,
    input  wire logic [1:0]                 cfg_index,
    input  wire logic [tcd_pkg::WORD_W-1:0] cfg_wdata,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire tcd_pkg::tcd_req_t          s_data,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output tcd_pkg::tcd_rsp_t               m_data
);
    import tcd_pkg::*;

    localparam int CNT_W = (TICK_BATCH_BITS < TICK_W) ? TICK_BATCH_BITS : TICK_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_TICK = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [WORD_W-1:0] rd_reg, rd_next;
    logic              m_valid_reg, m_valid_next;
    tcd_rsp_t          m_data_reg, m_data_next;
    logic [WORD_W-1:0] start_mask_reg, update_mask_reg, expiry_bits_reg;

    logic              accept;
    logic              out_free;
    logic [CNT_W-1:0]  tick_masked;
    logic [WORD_W-1:0] bus_rd;
    tcd_ctrl_t         ctrl;
    tcd_stat_t         stat;

    assign s_ready     = (state_reg == ST_IDLE);
    assign accept      = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign tick_masked = s_data.tick_count[CNT_W-1:0];
    assign m_valid     = m_valid_reg;
    assign m_data      = m_data_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_mask_reg  <= START_MASK_RST;
            update_mask_reg <= UPDATE_MASK_RST;
            expiry_bits_reg <= EXPIRY_BITS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_START:  start_mask_reg  <= cfg_wdata;
                CFG_UPDATE: update_mask_reg <= cfg_wdata;
                CFG_EXPIRY: expiry_bits_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    tcd_regfile u_regs (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (ctrl),
        .reg_index    (s_data.register_index),
        .wr_data      (s_data.write_data),
        .tick_add_val (TICK_W'(tick_masked)),
        .start_mask   (start_mask_reg),
        .update_mask  (update_mask_reg),
        .expiry_bits  (expiry_bits_reg),
        .rd_data      (bus_rd),
        .stat         (stat)
    );

    // sequencer
    always_comb begin
        state_next   = state_reg;
        rem_next     = rem_reg;
        rd_next      = rd_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        ctrl         = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    ctrl.bus_wr   = (s_data.operation == OP_WRITE);
                    ctrl.tick_add = (s_data.operation == OP_TICK);
                    rd_next       = (s_data.operation == OP_READ) ? bus_rd : '0;
                    rem_next      = tick_masked;
                    if ((s_data.operation == OP_TICK) && stat.start_active
                        && (tick_masked != '0)) begin
                        state_next = ST_TICK;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_TICK: begin
                ctrl.step_en = 1'b1;
                rem_next     = rem_reg - CNT_W'(1);
                if (stat.step_stop || (rem_reg == CNT_W'(1))) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next            = 1'b1;
                    m_data_next.read_data   = rd_reg;
                    m_data_next.irq_pending = stat.irq_pending;
                    state_next              = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        rem_reg    <= rem_next;
        rd_reg     <= rd_next;
        m_data_reg <= m_data_next;
    end

    // the tick loop never runs with nothing left to count
    a_tick_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TICK) |-> (rem_reg != '0))
        else $error("tick loop running with zero remaining ticks");

    // an enabled nonzero batch enters the tick loop
    a_tick_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_data.operation == OP_TICK) && stat.start_active
         && (tick_masked != '0)) |=> (state_reg == ST_TICK))
        else $error("tick batch did not enter the tick loop");

    // a response is issued with the latch state left by its request
    a_rsp_irq: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DONE) && out_free)
        |=> (m_valid && (m_data.irq_pending == stat.irq_pending)))
        else $error("response irq_pending does not match the latch");

endmodule

`default_nettype wire

>>> tb/sv/tcd_resp_checker.sv
// Response checker for the periodic down-counter timer: mirrors the timer
// registers, predicts one response per request and compares it with the DUT.
// Depends on tcd_pkg.
`timescale 1ns / 1ps

module tcd_resp_checker #(
    parameter int TICK_BITS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [1:0]                 cfg_index,
    input  logic [tcd_pkg::WORD_W-1:0] cfg_wdata,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  tcd_pkg::tcd_req_t          s_data,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  tcd_pkg::tcd_rsp_t          m_data,
    output int                         fail_count,
    output int                         pending_count
);
    import tcd_pkg::*;

    // mirrored configuration
    logic [WORD_W-1:0] start_mask;
    logic [WORD_W-1:0] update_mask;
    logic [WORD_W-1:0] expiry_bits;

    // mirrored timer state
    logic [63:0]       tick_total;
    logic [WORD_W-1:0] gcfg_word;
    logic [WORD_W-1:0] tcfg_word;
    logic [WORD_W-1:0] state_word;
    logic [WORD_W-1:0] count_buf;
    logic [WORD_W-1:0] count_buf2;
    logic [WORD_W-1:0] live_cnt;
    logic [WORD_W-1:0] irq_bits;

    // responses owed by the DUT, oldest first
    tcd_rsp_t owed_replies[$];

    task automatic clear_timer();
        start_mask  = START_MASK_RST;
        update_mask = UPDATE_MASK_RST;
        expiry_bits = EXPIRY_BITS_RST;
        tick_total  = '0;
        gcfg_word   = '0;
        tcfg_word   = '0;
        state_word  = '0;
        count_buf   = '0;
        count_buf2  = '0;
        live_cnt    = '0;
        irq_bits    = '0;
    endtask

    // run a batch of ticks through the free-running and reloading counters
    task automatic run_tick_batch(input logic [TICK_W-1:0] batch);
        int unsigned n;
        n = (TICK_BITS >= 32) ? batch : (batch & ((32'd1 << TICK_BITS) - 1));
        tick_total += 64'(n);
        if ((state_word & start_mask) != '0) begin
            while (n > 0) begin
                n--;
                if (live_cnt == '0) begin
                    live_cnt = count_buf;
                    // empty buffer stops the down-counter
                    if (live_cnt == '0) break;
                end
                live_cnt--;
                if (live_cnt == '0) begin
                    irq_bits |= expiry_bits;
                    live_cnt  = count_buf;
                end
            end
        end
    endtask

    // apply one request to the mirror and work out its response
    task automatic advance_timer(input tcd_req_t r, output tcd_rsp_t rsp);
        logic [WORD_W-1:0] rd;
        logic [WORD_W-1:0] d;
        rd = '0;
        d  = r.write_data;
        case (r.operation)
            OP_READ: begin
                case (r.register_index)
                    REG_TICKS_LO: rd = tick_total[31:0];
                    REG_TICKS_HI: rd = tick_total[63:32];
                    REG_GCFG:     rd = gcfg_word;
                    REG_TCFG:     rd = tcfg_word;
                    REG_STATE:    rd = state_word;
                    REG_BUF:      rd = count_buf;
                    REG_BUF2:     rd = count_buf2;
                    REG_VALUE:    rd = live_cnt;
                    REG_LATCH:    rd = irq_bits;
                    REG_STATUS:   rd = irq_bits;
                    default:      rd = '0;
                endcase
            end
            OP_WRITE: begin
                case (r.register_index)
                    REG_GCFG: gcfg_word = d;
                    REG_TCFG: tcfg_word = d;
                    REG_STATE: begin
                        state_word = d;
                        if ((d & update_mask) != '0) live_cnt = count_buf;
                    end
                    REG_BUF: begin
                        count_buf = d;
                        live_cnt  = d;
                    end
                    REG_BUF2:           count_buf2 = d;
                    REG_LATCH, REG_ACK: irq_bits &= ~d;
                    REG_STATUS:         irq_bits = '0;
                    default: ;
                endcase
            end
            OP_TICK: run_tick_batch(r.tick_count);
            default: ;
        endcase
        rsp.read_data   = rd;
        rsp.irq_pending = (irq_bits != '0);
    endtask

    // sample both channels and the config port at each edge
    always @(posedge aclk) begin : watch
        tcd_rsp_t want;
        if (!aresetn) begin
            clear_timer();
            owed_replies.delete();
            fail_count    = 0;
            pending_count = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_START:  start_mask  = cfg_wdata;
                    CFG_UPDATE: update_mask = cfg_wdata;
                    CFG_EXPIRY: expiry_bits = cfg_wdata;
                    default: ;
                endcase
            end

            // responses are checked before this edge's request is predicted
            if (m_valid && m_ready) begin
                if (owed_replies.size() == 0) begin
                    $display("%0t: response with none owed: got %h", $time, m_data);
                    fail_count++;
                end else begin
                    want = owed_replies.pop_front();
                    if (m_data.read_data !== want.read_data) begin
                        $display("%0t: read_data mismatch: expected %h, got %h",
                                 $time, want.read_data, m_data.read_data);
                        fail_count++;
                    end
                    if (m_data.irq_pending !== want.irq_pending) begin
                        $display("%0t: irq_pending mismatch: expected %b, got %b",
                                 $time, want.irq_pending, m_data.irq_pending);
                        fail_count++;
                    end
                end
            end

            if (s_valid && s_ready) begin
                advance_timer(s_data, want);
                owed_replies.push_back(want);
            end
            pending_count = owed_replies.size();
        end
    end

endmodule

>>> tb/sv/tb_timer_counter_decrementer_regs_top.sv
// Testbench top for the periodic down-counter timer: clock, reset, request
// stimulus, response back-pressure and config phases; checking is done by
// tcd_resp_checker. Depends on tcd_pkg and timer_counter_decrementer_regs_top.
`timescale 1ns / 1ps

module tb_timer_counter_decrementer_regs_top;
    import tcd_pkg::*;

    localparam int         TICK_BITS    = 16;
    localparam logic [3:0] REG_UNMAPPED = 4'd15;
    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         HOLD_CYCLES  = 300;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              cfg_wr_en;
    logic [1:0]        cfg_index;
    logic [WORD_W-1:0] cfg_wdata;
    logic              s_valid;
    logic              s_ready;
    tcd_req_t          s_data;
    logic              m_valid;
    logic              m_ready;
    tcd_rsp_t          m_data;
    int                fail_count;
    int                pending_count;

    // stimulus-side copy of the config, used to shape requests
    logic [WORD_W-1:0] cur_start;
    logic [WORD_W-1:0] cur_update;
    logic [WORD_W-1:0] cur_expiry;

    bit idle_on;
    bit hold_req;
    int big_left;

    tcd_req_t directed_q[$];

    timer_counter_decrementer_regs_top #(
        .TICK_BATCH_BITS(TICK_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    tcd_resp_checker #(
        .TICK_BITS(TICK_BITS)
    ) checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .fail_count   (fail_count),
        .pending_count(pending_count)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // run limit, several times the slowest legal run
    initial begin
        #30_000_000;
        $display("tb_timer_counter_decrementer_regs_top: FAIL");
        $finish;
    end

    // response side: random stall bursts plus one long hold-off on request
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        m_ready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_ready  <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_ready  <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    function automatic tcd_req_t mk_req(logic [1:0] op, logic [3:0] idx,
                                        logic [WORD_W-1:0] d, logic [TICK_W-1:0] n);
        tcd_req_t r;
        r.operation      = op;
        r.register_index = idx;
        r.write_data     = d;
        r.tick_count     = n;
        return r;
    endfunction

    // random request, mostly well-formed timer programming with some noise
    function automatic tcd_req_t rand_request();
        tcd_req_t    r;
        int unsigned pick;
        r.operation      = OP_READ;
        r.register_index = 4'($urandom_range(0, 15));
        r.write_data     = $urandom();
        r.tick_count     = 16'($urandom());
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            r.operation = OP_TICK;
            if (big_left > 0 && $urandom_range(0, 199) == 0) begin
                big_left--;
                r.tick_count = 16'($urandom_range(0, 65535));
            end else if ($urandom_range(0, 3) == 0) begin
                r.tick_count = 16'($urandom_range(0, 3));
            end else begin
                r.tick_count = 16'($urandom_range(0, 31));
            end
        end else if (pick < 45) begin
            r.operation      = OP_WRITE;
            r.register_index = REG_BUF;
            if ($urandom_range(0, 7) != 0) r.write_data = $urandom_range(0, 12);
        end else if (pick < 55) begin
            r.operation      = OP_WRITE;
            r.register_index = REG_STATE;
            case ($urandom_range(0, 3))
                0: r.write_data = cur_start;
                1: r.write_data = cur_start | cur_update;
                2: r.write_data = ($urandom_range(0, 1) == 0) ? '0 : cur_update;
                default: ;
            endcase
        end else if (pick < 75) begin
            r.operation = OP_READ;
        end else if (pick < 85) begin
            r.operation = OP_WRITE;
            case ($urandom_range(0, 2))
                0: r.register_index = REG_LATCH;
                1: r.register_index = REG_ACK;
                default: r.register_index = REG_STATUS;
            endcase
            if ($urandom_range(0, 1) == 0) r.write_data = cur_expiry;
        end else if (pick < 95) begin
            r.operation = OP_WRITE;
        end else begin
            r.operation = 2'($urandom_range(0, 3));
        end
        return r;
    endfunction

    // hand one request over and return at the edge that takes it
    task automatic send_request(input tcd_req_t r);
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // optional sender gap after a request
    task automatic pace();
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
    endtask

    task automatic run_directed();
        foreach (directed_q[i]) begin
            send_request(directed_q[i]);
            pace();
        end
        s_valid <= 1'b0;
    endtask

    task automatic run_random(input int count, input int hold_at);
        tcd_req_t req;
        for (int i = 0; i < count; i++) begin
            if (i == hold_at) hold_req <= 1'b1;
            req = rand_request();
            send_request(req);
            pace();
        end
        s_valid <= 1'b0;
    endtask

    // wait until every owed response has come back
    task automatic settle();
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // write all three config registers on consecutive edges
    task automatic set_config(input logic [WORD_W-1:0] st, input logic [WORD_W-1:0] up,
                              input logic [WORD_W-1:0] ex);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_START;
        cfg_wdata <= st;
        @(posedge aclk);
        cfg_index <= CFG_UPDATE;
        cfg_wdata <= up;
        @(posedge aclk);
        cfg_index <= CFG_EXPIRY;
        cfg_wdata <= ex;
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        cur_start  = st;
        cur_update = up;
        cur_expiry = ex;
    endtask

    initial begin
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_START;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cur_start  = START_MASK_RST;
        cur_update = UPDATE_MASK_RST;
        cur_expiry = EXPIRY_BITS_RST;
        idle_on    = 1'b1;
        hold_req   = 1'b0;
        big_left   = 4;

        // directed: register map, expiry and clearing, update, stop, long batch
        directed_q.push_back(mk_req(OP_READ,   REG_TICKS_LO, '0, '0));
        directed_q.push_back(mk_req(OP_READ,   REG_UNMAPPED, '1, '1));
        directed_q.push_back(mk_req(OP_WRITE,  REG_GCFG,     '1, '0));
        directed_q.push_back(mk_req(OP_WRITE,  REG_BUF2,     '1, '0));
        directed_q.push_back(mk_req(OP_WRITE,  REG_BUF,      32'd3, '0));
        directed_q.push_back(mk_req(OP_WRITE,  REG_STATE,    START_MASK_RST, '0));
        directed_q.push_back(mk_req(OP_TICK,   REG_TICKS_LO, '0, 16'd0));
        directed_q.push_back(mk_req(OP_TICK,   REG_TICKS_LO, '0, 16'd2));
        directed_q.push_back(mk_req(OP_TICK,   REG_TICKS_LO, '0, 16'd1));
        directed_q.push_back(mk_req(OP_READ,   REG_STATUS,   '0, '0));
        directed_q.push_back(mk_req(OP_WRITE,  REG_ACK,      EXPIRY_BITS_RST, '0));
        directed_q.push_back(mk_req(OP_READ,   REG_ACK,      '0, '0));
        directed_q.push_back(mk_req(OP_TICK,   REG_TICKS_LO, '0, 16'd3));
        directed_q.push_back(mk_req(OP_WRITE,  REG_LATCH,    '1, '0));
        directed_q.push_back(mk_req(OP_TICK,   REG_TICKS_LO, '0, 16'd3));
        directed_q.push_back(mk_req(OP_WRITE,  REG_STATUS,   '0, '0));
        directed_q.push_back(mk_req(OP_WRITE,  REG_VALUE,    32'd55, '0));
        directed_q.push_back(mk_req(OP_WRITE,  REG_TICKS_HI, 32'd1, '0));
        directed_q.push_back(mk_req(OP_TICK,   REG_TICKS_LO, '0, 16'd1));
        directed_q.push_back(mk_req(OP_WRITE,  REG_STATE,
                                    START_MASK_RST | UPDATE_MASK_RST, '0));
        directed_q.push_back(mk_req(OP_READ,   REG_VALUE,    '0, '0));
        directed_q.push_back(mk_req(OP_UNUSED, REG_STATE,    '1, '1));
        directed_q.push_back(mk_req(OP_WRITE,  REG_BUF,      '0, '0));
        directed_q.push_back(mk_req(OP_TICK,   REG_TICKS_LO, '0, 16'd5));
        directed_q.push_back(mk_req(OP_WRITE,  REG_BUF,      32'd7, '0));
        directed_q.push_back(mk_req(OP_TICK,   REG_TICKS_LO, '0, 16'hFFFF));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset config
        run_directed();
        run_random(200, -1);

        // every mask bit set; long response hold-off partway through
        settle();
        set_config('1, '1, '1);
        run_random(200, 30);

        // counting disabled, no update, no interrupt bits
        settle();
        set_config('0, '0, '0);
        run_random(100, -1);

        // single random start and update bits, random interrupt bits
        settle();
        set_config(32'd1 << $urandom_range(0, 31), 32'd1 << $urandom_range(0, 31),
                   $urandom());
        run_random(250, -1);

        // back to reset values, no idling on either side
        settle();
        idle_on = 1'b0;
        set_config(START_MASK_RST, UPDATE_MASK_RST, EXPIRY_BITS_RST);
        run_random(250, -1);

        settle();
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb_timer_counter_decrementer_regs_top: PASS");
        end else begin
            $display("tb_timer_counter_decrementer_regs_top: FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/tcd_pkg.sv
hw/rtl/tcd_tick_step.sv
hw/rtl/tcd_regfile.sv
hw/rtl/timer_counter_decrementer_regs_top.sv
tb/sv/tcd_resp_checker.sv
tb/sv/tb_timer_counter_decrementer_regs_top.sv
